### hdl/array_list_insert_delete_defines.svh
// Assertion macros for the ordered list block.
// Taken in by the RTL files that carry concurrent checks; no other dependencies.
`ifndef ARRAY_LIST_INSERT_DELETE_DEFINES_SVH
`define ARRAY_LIST_INSERT_DELETE_DEFINES_SVH

`ifndef SYNTHESIS
`define ALI_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ali assertion failed");
`define ALI_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("ali reset assertion failed");
`else
`define ALI_ASSERT(lbl, prop)
`define ALI_ASSERT_RST(lbl, prop)
`endif

`endif

### hdl/ali_pkg.sv
// Shared types and constants for the ordered list block.
// No dependencies; used by ali_cell and array_list_insert_delete.
`timescale 1ns / 1ps

package ali_pkg;

  localparam int CAPACITY_DEF = 16;

  localparam int KIND_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 8;
  localparam int STATUS_W = 2;
  localparam int FIDX_W   = 4;
  localparam int COUNT_W  = 5;

  typedef enum logic [KIND_W-1:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_FIND   = 3'd2,
    OP_READ   = 3'd3,
    OP_CLEAR  = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BADPOS   = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } state_t;

  // broadcast to every cell
  typedef struct packed {
    logic               ins;
    logic               del;
    logic               find;
    logic               rd;
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   pos;
  } cell_cmd_t;

endpackage

### hdl/array_list_insert_delete.sv
// Top level of the ordered list block: control, fill count, result register
// and the chain of ali_cell instances. Uses ali_pkg and the defines header.
//
// Ordered list of up to CAPACITY signed 32-bit elements kept in a chain of
// cells, one element per cell. For insert, delete, clear and the unused kinds
// the result is registered at the accepting edge; a new transaction can be
// taken in the next cycle if out_ready is high then. Find and read send a
// search wave down the chain one cell per cycle; the result is registered once
// the scan counter reaches CAPACITY, and no input is taken meanwhile. The count
// and found_index outputs are the low bits of the internal values.
`timescale 1ns / 1ps
`include "array_list_insert_delete_defines.svh"

module array_list_insert_delete #(
  parameter int CAPACITY = ali_pkg::CAPACITY_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic        [ali_pkg::KIND_W-1:0]   in_kind,
  input  logic signed [ali_pkg::VALUE_W-1:0]  in_value,
  input  logic        [ali_pkg::POS_W-1:0]    in_position,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic        [ali_pkg::STATUS_W-1:0] out_status,
  output logic signed [ali_pkg::VALUE_W-1:0]  out_element,
  output logic        [ali_pkg::FIDX_W-1:0]   out_found_index,
  output logic        [ali_pkg::COUNT_W-1:0]  out_count
);

  localparam int FILL_W = $clog2(CAPACITY + 1);
  localparam int IW     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW     = ((FILL_W > ali_pkg::POS_W) ? FILL_W : ali_pkg::POS_W) + 1;
  localparam logic [FILL_W-1:0] CAP_F = FILL_W'(CAPACITY);
  localparam logic [CW-1:0]     CAP_C = CW'(CAPACITY);

  ali_pkg::state_t state_r, state_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [FILL_W-1:0] scan_cnt_r, scan_cnt_nxt;
  logic              is_find_r;
  logic [ali_pkg::VALUE_W-1:0] val_r;
  logic [ali_pkg::POS_W-1:0]   pos_r;

  logic                         out_valid_r;
  logic [ali_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [ali_pkg::VALUE_W-1:0]  out_element_r, out_element_nxt;
  logic [ali_pkg::FIDX_W-1:0]   out_found_index_r, out_found_index_nxt;
  logic [ali_pkg::COUNT_W-1:0]  out_count_r;

  logic scanning;
  logic scan_done;
  logic accept;
  logic start_scan;
  logic ins_ok;
  logic del_ok;
  logic load_out;

  logic [CW-1:0] pos_e;
  logic [CW-1:0] fill_e;
  logic [FILL_W+ali_pkg::COUNT_W-1:0] count_ext;
  logic [IW+ali_pkg::FIDX_W-1:0]      idx_ext;

  ali_pkg::cell_cmd_t cmd;

  logic [ali_pkg::VALUE_W-1:0] slots  [CAPACITY];
  logic                        w_hit  [CAPACITY+1];
  logic [ali_pkg::VALUE_W-1:0] w_data [CAPACITY+1];
  logic [IW-1:0]               w_idx  [CAPACITY+1];

  // ---- FSM ----
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ali_pkg::S_IDLE: begin
        if (start_scan) begin
          state_nxt = ali_pkg::S_SCAN;
        end
      end
      ali_pkg::S_SCAN: begin
        if (scan_done) begin
          state_nxt = ali_pkg::S_IDLE;
        end
      end
      default: state_nxt = ali_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    scanning = 1'b0;
    case (state_r)
      ali_pkg::S_IDLE: in_ready = !out_valid_r || out_ready;
      ali_pkg::S_SCAN: scanning = 1'b1;
      default: in_ready = 1'b0;
    endcase
  end

  assign accept     = in_valid && in_ready;
  assign start_scan = accept && (in_kind inside {ali_pkg::OP_FIND, ali_pkg::OP_READ});
  assign scan_done  = scanning && (scan_cnt_r == CAP_F);
  assign load_out   = (accept && !start_scan) || scan_done;

  // ---- position checks ----
  assign pos_e  = {{(CW-ali_pkg::POS_W){1'b0}}, in_position};
  assign fill_e = {{(CW-FILL_W){1'b0}}, fill_r};

  assign ins_ok = accept && (in_kind == ali_pkg::OP_INSERT) && (fill_e < CAP_C) &&
                  (pos_e != '0) && (pos_e <= fill_e + CW'(1));
  assign del_ok = accept && (in_kind == ali_pkg::OP_DELETE) &&
                  (pos_e != '0) && (pos_e <= fill_e);

  always_comb begin
    fill_nxt = fill_r;
    if (ins_ok) begin
      fill_nxt = fill_r + FILL_W'(1);
    end else if (del_ok) begin
      fill_nxt = fill_r - FILL_W'(1);
    end else if (accept && (in_kind == ali_pkg::OP_CLEAR)) begin
      fill_nxt = '0;
    end
  end

  always_comb begin
    scan_cnt_nxt = scan_cnt_r;
    if (start_scan) begin
      scan_cnt_nxt = '0;
    end else if (scanning && !scan_done) begin
      scan_cnt_nxt = scan_cnt_r + FILL_W'(1);
    end
  end

  // ---- cell command ----
  always_comb begin
    cmd       = '0;
    cmd.ins   = ins_ok;
    cmd.del   = del_ok;
    cmd.find  = scanning && is_find_r;
    cmd.rd    = scanning && !is_find_r;
    cmd.value = scanning ? val_r : in_value;
    cmd.pos   = scanning ? pos_r : in_position;
  end

  // ---- cell chain ----
  assign w_hit[0]  = 1'b0;
  assign w_data[0] = '0;
  assign w_idx[0]  = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ali_pkg::VALUE_W-1:0] left_s;
    logic [ali_pkg::VALUE_W-1:0] right_s;

    if (i == 0) begin : g_first
      assign left_s = slots[i];
    end else begin : g_mid_l
      assign left_s = slots[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_s = slots[i];
    end else begin : g_mid_r
      assign right_s = slots[i+1];
    end

    ali_cell #(
      .IDX    (i),
      .FILL_W (FILL_W),
      .IW     (IW)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .fill       (fill_r),
      .left_slot  (left_s),
      .right_slot (right_s),
      .slot       (slots[i]),
      .w_hit_in   (w_hit[i]),
      .w_data_in  (w_data[i]),
      .w_idx_in   (w_idx[i]),
      .w_hit_out  (w_hit[i+1]),
      .w_data_out (w_data[i+1]),
      .w_idx_out  (w_idx[i+1])
    );
  end

  // ---- result ----
  assign count_ext = {{ali_pkg::COUNT_W{1'b0}}, fill_nxt};
  assign idx_ext   = {{ali_pkg::FIDX_W{1'b0}}, w_idx[CAPACITY]};

  always_comb begin
    out_status_nxt      = ali_pkg::ST_OK;
    out_element_nxt     = '0;
    out_found_index_nxt = '0;
    if (scanning) begin
      if (is_find_r) begin
        if (w_hit[CAPACITY]) begin
          out_found_index_nxt = idx_ext[ali_pkg::FIDX_W-1:0];
        end else begin
          out_status_nxt = ali_pkg::ST_NOTFOUND;
        end
      end else begin
        if (w_hit[CAPACITY]) begin
          out_element_nxt = w_data[CAPACITY];
        end else begin
          out_status_nxt = ali_pkg::ST_BADPOS;
        end
      end
    end else begin
      case (in_kind)
        ali_pkg::OP_INSERT: begin
          if (fill_e >= CAP_C) begin
            out_status_nxt = ali_pkg::ST_FULL;
          end else if (!ins_ok) begin
            out_status_nxt = ali_pkg::ST_BADPOS;
          end
        end
        ali_pkg::OP_DELETE: begin
          if (!del_ok) begin
            out_status_nxt = ali_pkg::ST_BADPOS;
          end
        end
        default: out_status_nxt = ali_pkg::ST_OK;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ali_pkg::S_IDLE;
      fill_r      <= '0;
      scan_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      fill_r     <= fill_nxt;
      scan_cnt_r <= scan_cnt_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_scan) begin
      is_find_r <= (in_kind == ali_pkg::OP_FIND);
      val_r     <= in_value;
      pos_r     <= in_position;
    end
    if (load_out) begin
      out_status_r      <= out_status_nxt;
      out_element_r     <= out_element_nxt;
      out_found_index_r <= out_found_index_nxt;
      out_count_r       <= count_ext[ali_pkg::COUNT_W-1:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_element     = out_element_r;
  assign out_found_index = out_found_index_r;
  assign out_count       = out_count_r;

  // ---- checks ----
  `ALI_ASSERT(a_fill_cap, fill_r <= CAP_F)
  `ALI_ASSERT(a_scan_cnt, scan_cnt_r <= CAP_F)
  `ALI_ASSERT(a_scan_blocks, scanning |-> !in_ready)
  `ALI_ASSERT(a_scan_start, start_scan |=> (state_r == ali_pkg::S_SCAN) && (scan_cnt_r == '0))
  `ALI_ASSERT(a_ins_grows, ins_ok |=> fill_r == $past(fill_r) + FILL_W'(1))
  `ALI_ASSERT_RST(a_reset_idle, !rst_n |=> !out_valid && (fill_r == '0))

endmodule

### hdl/ali_cell.sv
// One storage cell of the list chain: holds one element, shifts with its
// neighbors on insert/delete, and forwards the search wave. Uses ali_pkg.
`timescale 1ns / 1ps

module ali_cell #(
  parameter int IDX    = 0,
  parameter int FILL_W = 5,
  parameter int IW     = 4
) (
  input  logic                      clk,
  input  ali_pkg::cell_cmd_t        cmd,
  input  logic [FILL_W-1:0]         fill,
  input  logic [ali_pkg::VALUE_W-1:0] left_slot,
  input  logic [ali_pkg::VALUE_W-1:0] right_slot,
  output logic [ali_pkg::VALUE_W-1:0] slot,
  input  logic                      w_hit_in,
  input  logic [ali_pkg::VALUE_W-1:0] w_data_in,
  input  logic [IW-1:0]             w_idx_in,
  output logic                      w_hit_out,
  output logic [ali_pkg::VALUE_W-1:0] w_data_out,
  output logic [IW-1:0]             w_idx_out
);

  localparam int CW = ((FILL_W > ali_pkg::POS_W) ? FILL_W : ali_pkg::POS_W) + 1;
  localparam logic [CW-1:0]     POS_HERE = CW'(IDX + 1);
  localparam logic [FILL_W-1:0] IDX_F    = FILL_W'(IDX);
  localparam logic [IW-1:0]     IDX_I    = IW'(IDX);

  logic [ali_pkg::VALUE_W-1:0] slot_r, slot_nxt;
  logic                        w_hit_r, w_hit_nxt;
  logic [ali_pkg::VALUE_W-1:0] w_data_r, w_data_nxt;
  logic [IW-1:0]               w_idx_r, w_idx_nxt;
  logic [CW-1:0]               pos_e;
  logic                        in_use;
  logic                        match;

  assign pos_e  = {{(CW-ali_pkg::POS_W){1'b0}}, cmd.pos};
  assign in_use = (fill > IDX_F);
  assign match  = in_use && ((cmd.find && (slot_r == cmd.value)) ||
                             (cmd.rd && (pos_e == POS_HERE)));

  always_comb begin
    slot_nxt = slot_r;
    if (cmd.ins) begin
      if (pos_e == POS_HERE) begin
        slot_nxt = cmd.value;
      end else if (pos_e < POS_HERE) begin
        slot_nxt = left_slot;
      end
    end else if (cmd.del) begin
      if (pos_e <= POS_HERE) begin
        slot_nxt = right_slot;
      end
    end
  end

  always_comb begin
    w_hit_nxt  = w_hit_in;
    w_data_nxt = w_data_in;
    w_idx_nxt  = w_idx_in;
    if (!w_hit_in && match) begin
      w_hit_nxt  = 1'b1;
      w_data_nxt = slot_r;
      w_idx_nxt  = IDX_I;
    end
  end

  always_ff @(posedge clk) begin
    slot_r   <= slot_nxt;
    w_hit_r  <= w_hit_nxt;
    w_data_r <= w_data_nxt;
    w_idx_r  <= w_idx_nxt;
  end

  assign slot       = slot_r;
  assign w_hit_out  = w_hit_r;
  assign w_data_out = w_data_r;
  assign w_idx_out  = w_idx_r;

endmodule

### dv/array_list_insert_delete_tb.sv
// Self-checking testbench for array_list_insert_delete: random and directed list operations
// are compared against an in-bench list that is kept in step with the block.
// Depends on ali_pkg and the array_list_insert_delete RTL.
`timescale 1ns / 1ps

module array_list_insert_delete_tb;

  localparam int LIST_CAP    = ali_pkg::CAPACITY_DEF;
  localparam int MAX_IDLE    = 11;
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;
  localparam int SHOW_LIMIT  = 10;

  typedef logic [ali_pkg::KIND_W-1:0] kind_t;
  typedef logic [ali_pkg::POS_W-1:0]  pos_t;

  localparam kind_t KIND_UNUSED_FIRST = 3'd5;
  localparam kind_t KIND_UNUSED_MID   = 3'd6;
  localparam kind_t KIND_UNUSED_LAST  = 3'd7;

  typedef struct {
    ali_pkg::status_t                    status;
    logic signed [ali_pkg::VALUE_W-1:0]  element;
    logic        [ali_pkg::FIDX_W-1:0]   found_index;
    logic        [ali_pkg::COUNT_W-1:0]  count;
  } list_result_t;

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                in_valid = 1'b0;
  logic                                in_ready;
  logic        [ali_pkg::KIND_W-1:0]   in_kind = '0;
  logic signed [ali_pkg::VALUE_W-1:0]  in_value = '0;
  logic        [ali_pkg::POS_W-1:0]    in_position = '0;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  logic        [ali_pkg::STATUS_W-1:0] out_status;
  logic signed [ali_pkg::VALUE_W-1:0]  out_element;
  logic        [ali_pkg::FIDX_W-1:0]   out_found_index;
  logic        [ali_pkg::COUNT_W-1:0]  out_count;

  logic signed [ali_pkg::VALUE_W-1:0] list_slots [LIST_CAP];
  int                                 list_fill = 0;
  list_result_t                       pending_results [$];

  bit send_idle_en = 1'b1;
  bit recv_idle_en = 1'b1;
  int ready_hold = 0;

  int n_sent = 0;
  int n_checked = 0;
  int n_mismatch = 0;
  int n_by_kind [8];
  int n_by_status [4];
  int n_full_reached = 0;
  int stall_cycles = 0;

  array_list_insert_delete #(.CAPACITY(LIST_CAP)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_value        (in_value),
    .in_position     (in_position),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_element     (out_element),
    .out_found_index (out_found_index),
    .out_count       (out_count)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic list_result_t apply_list_op(
      input kind_t kind, input logic signed [ali_pkg::VALUE_W-1:0] value,
      input pos_t position);
    list_result_t r;
    int p;
    int j;
    r.status = ali_pkg::ST_OK;
    r.element = '0;
    r.found_index = '0;
    p = position;
    case (kind)
      ali_pkg::OP_INSERT: begin
        if (list_fill >= LIST_CAP) begin
          r.status = ali_pkg::ST_FULL;
        end else if (p < 1 || p > list_fill + 1) begin
          r.status = ali_pkg::ST_BADPOS;
        end else begin
          for (j = list_fill; j >= p; j--) list_slots[j] = list_slots[j-1];
          list_slots[p-1] = value;
          list_fill++;
        end
      end
      ali_pkg::OP_DELETE: begin
        if (p < 1 || p > list_fill) begin
          r.status = ali_pkg::ST_BADPOS;
        end else begin
          for (j = p; j < list_fill; j++) list_slots[j-1] = list_slots[j];
          list_fill--;
        end
      end
      ali_pkg::OP_FIND: begin
        r.status = ali_pkg::ST_NOTFOUND;
        for (j = 0; j < list_fill; j++) begin
          if (list_slots[j] == value) begin
            r.status = ali_pkg::ST_OK;
            r.found_index = j[ali_pkg::FIDX_W-1:0];
            break;
          end
        end
      end
      ali_pkg::OP_READ: begin
        if (p < 1 || p > list_fill) r.status = ali_pkg::ST_BADPOS;
        else r.element = list_slots[p-1];
      end
      ali_pkg::OP_CLEAR: begin
        list_fill = 0;
      end
      default: begin
      end
    endcase
    r.count = list_fill[ali_pkg::COUNT_W-1:0];
    return r;
  endfunction

  // Called right after an acceptance (or a pause), so valid is touched once per step.
  task automatic send_op(input kind_t kind, input logic signed [ali_pkg::VALUE_W-1:0] value,
                         input pos_t position);
    int gap;
    list_result_t r;
    gap = send_idle_en ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_kind     <= kind;
    in_value    <= value;
    in_position <= position;
    do @(posedge clk); while (!in_ready);
    r = apply_list_op(kind, value, position);
    pending_results.push_back(r);
    n_sent++;
    n_by_kind[kind]++;
    n_by_status[r.status]++;
    if (kind == ali_pkg::OP_INSERT && r.status == ali_pkg::ST_OK && list_fill == LIST_CAP)
      n_full_reached++;
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (LIST_CAP + 4) @(posedge clk);
  endtask

  function automatic logic signed [ali_pkg::VALUE_W-1:0] choose_value();
    logic signed [ali_pkg::VALUE_W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2: v = (list_fill > 0) ? list_slots[$urandom_range(0, list_fill - 1)] : $urandom;
      3: begin
        case ($urandom_range(0, 4))
          0: v = 32'sh8000_0000;
          1: v = 32'sh7fff_ffff;
          2: v = -1;
          3: v = 0;
          default: v = 1;
        endcase
      end
      4: v = $urandom_range(0, 7);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic test_empty_list();
    send_op(ali_pkg::OP_READ, 0, 1);
    send_op(ali_pkg::OP_DELETE, 0, 1);
    send_op(ali_pkg::OP_FIND, 0, 0);
    send_op(ali_pkg::OP_INSERT, 5, 0);
    send_op(ali_pkg::OP_INSERT, 5, 2);
    send_op(KIND_UNUSED_FIRST, -1, 8'hff);
  endtask

  task automatic test_fill_and_edges();
    send_op(ali_pkg::OP_INSERT, 32'sh8000_0000, 1);
    send_op(ali_pkg::OP_INSERT, 32'sh7fff_ffff, 1);
    send_op(ali_pkg::OP_INSERT, -1, 3);
    while (list_fill < LIST_CAP - 1)
      send_op(ali_pkg::OP_INSERT, (list_fill % 4 == 0) ? -1 : list_fill,
              pos_t'($urandom_range(1, list_fill + 1)));
    send_op(ali_pkg::OP_INSERT, 32'sh1234_5678, pos_t'(list_fill + 1));
    send_op(ali_pkg::OP_INSERT, 9, 8'hff);
    send_op(ali_pkg::OP_INSERT, 9, 1);
    send_op(ali_pkg::OP_FIND, 32'sh1234_5678, 0);
    send_op(ali_pkg::OP_FIND, -1, 0);
    send_op(ali_pkg::OP_FIND, 32'sh5555_5555, 0);
    send_op(ali_pkg::OP_READ, 0, pos_t'(LIST_CAP));
    send_op(ali_pkg::OP_READ, 0, pos_t'(LIST_CAP + 1));
    send_op(ali_pkg::OP_DELETE, 0, pos_t'(LIST_CAP));
    send_op(ali_pkg::OP_DELETE, 0, 1);
    send_op(ali_pkg::OP_CLEAR, 0, 0);
    send_op(KIND_UNUSED_LAST, 32'sh7fff_ffff, 8'h80);
  endtask

  // Random walk between empty and full; mostly legal positions, some out of range.
  task automatic test_random_traffic(input int n_items);
    int i;
    int r;
    bit grow;
    kind_t kind;
    pos_t position;
    int limit;
    grow = (list_fill < LIST_CAP / 2);
    for (i = 0; i < n_items; i++) begin
      r = $urandom_range(0, 99);
      if (r < 2) kind = ali_pkg::OP_CLEAR;
      else if (r < 4) kind = kind_t'($urandom_range(KIND_UNUSED_FIRST, KIND_UNUSED_LAST));
      else if (r < 48)
        kind = ($urandom_range(0, 99) < (grow ? 75 : 25)) ? ali_pkg::OP_INSERT
                                                          : ali_pkg::OP_DELETE;
      else if (r < 74) kind = ali_pkg::OP_FIND;
      else kind = ali_pkg::OP_READ;
      limit = (kind == ali_pkg::OP_INSERT) ? list_fill + 1 : list_fill;
      if ($urandom_range(0, 9) == 0 || limit == 0) begin
        case ($urandom_range(0, 2))
          0: position = 0;
          1: position = pos_t'(limit + 1);
          default: position = pos_t'($urandom_range(0, 255));
        endcase
      end else begin
        position = pos_t'($urandom_range(1, limit));
      end
      send_op(kind, choose_value(), position);
      if (list_fill >= LIST_CAP && $urandom_range(0, 2) == 0) grow = 1'b0;
      else if (list_fill == 0) grow = 1'b1;
      else if ($urandom_range(0, 39) == 0) grow = ~grow;
    end
  endtask

  task automatic test_drain_pause(input int rounds);
    int k;
    for (k = 0; k < rounds; k++) begin
      test_random_traffic(15);
      wait_for_drain();
    end
  endtask

  task automatic test_backpressure(input int n_items);
    send_idle_en = 1'b0;
    ready_hold = HOLD_CYCLES;
    test_random_traffic(n_items);
    send_idle_en = 1'b1;
  endtask

  task automatic test_no_idle(input int n_items);
    send_idle_en = 1'b0;
    recv_idle_en = 1'b0;
    test_random_traffic(n_items);
    send_idle_en = 1'b1;
    recv_idle_en = 1'b1;
  endtask

  // Result receiver
  initial begin
    int gap;
    int hold;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (ready_hold > 0) begin
        hold = ready_hold;
        ready_hold = 0;
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end else begin
        gap = recv_idle_en ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && out_valid && out_ready) begin
      n_checked++;
      if (pending_results.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= SHOW_LIMIT)
          $display("%0t: unexpected transaction status=%0d element=%0d index=%0d count=%0d",
                   $realtime, out_status, out_element, out_found_index, out_count);
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status || out_element !== want.element ||
            out_found_index !== want.found_index || out_count !== want.count) begin
          n_mismatch++;
          if (n_mismatch <= SHOW_LIMIT)
            $display("%0t: mismatch status %0d/%0d element %0d/%0d index %0d/%0d count %0d/%0d",
                     $realtime, out_status, want.status, out_element, want.element,
                     out_found_index, want.found_index, out_count, want.count);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $realtime, STALL_LIMIT);
        $display("array_list_insert_delete regression: fail");
        $finish;
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_list();
    test_fill_and_edges();
    test_random_traffic(800);
    test_drain_pause(4);
    test_backpressure(60);
    test_no_idle(200);
    test_random_traffic(700);
    wait_for_drain();
    $display("covered %0d transactions: ins %0d del %0d find %0d read %0d clear %0d unused %0d",
             n_sent, n_by_kind[ali_pkg::OP_INSERT], n_by_kind[ali_pkg::OP_DELETE],
             n_by_kind[ali_pkg::OP_FIND], n_by_kind[ali_pkg::OP_READ],
             n_by_kind[ali_pkg::OP_CLEAR],
             n_by_kind[KIND_UNUSED_FIRST] + n_by_kind[KIND_UNUSED_MID] +
             n_by_kind[KIND_UNUSED_LAST]);
    $display("checked %0d results; full %0d, bad position %0d, not found %0d, filled %0d times",
             n_checked, n_by_status[ali_pkg::ST_FULL], n_by_status[ali_pkg::ST_BADPOS],
             n_by_status[ali_pkg::ST_NOTFOUND], n_full_reached);
    if (n_mismatch == 0 && pending_results.size() == 0) begin
      $display("array_list_insert_delete regression: pass");
    end else begin
      $display("array_list_insert_delete regression: fail");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hdl
hdl/ali_pkg.sv
hdl/ali_cell.sv
hdl/array_list_insert_delete.sv
dv/array_list_insert_delete_tb.sv
